// ===== design/ambient_cell_limit_smooth_macros.svh =====
// ----------------------------------------------------------------------------
// ambient_cell_limit_smooth assertion macros
// Shared concurrent check shorthands for the luminance limiter blocks.
// ----------------------------------------------------------------------------
`ifndef AMBIENT_CELL_LIMIT_SMOOTH_MACROS_SVH
`define AMBIENT_CELL_LIMIT_SMOOTH_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ACLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ambient_cell_limit_smooth: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ACLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ambient_cell_limit_smooth: next-cycle check failed");

`endif

// ===== design/acls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acls_pkg
// Types and constants shared by the luminance limiter and cell smoother.
// ----------------------------------------------------------------------------
package acls_pkg;

    // Grid size defaults
    localparam int GRID_COLUMNS_DEF = 12;
    localparam int GRID_ROWS_DEF    = 6;

    // Field widths
    localparam int IDX_W   = 7;
    localparam int PIX_W   = 8;
    localparam int CH_W    = 16;
    localparam int CFG_W   = 17;
    localparam int COLOR_W = 3 * CH_W;

    // Rec.709 weights in Q0.16, summing to 1.0
    localparam logic [CH_W-1:0] WEIGHT_R = 16'd13933;
    localparam logic [CH_W-1:0] WEIGHT_G = 16'd46871;
    localparam logic [CH_W-1:0] WEIGHT_B = 16'd4732;

    // One quotient bit per divider cell
    localparam int DIV_STEPS = CH_W;

    // Configuration register indexes
    localparam logic CFG_LUM_LIMIT = 1'b0;
    localparam logic CFG_SMOOTH    = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] LUM_LIMIT_RST = 17'h10000;
    localparam logic [CFG_W-1:0] SMOOTH_RST    = 17'h04000;

    // Request travelling down the divider chain
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             scale;
        logic [CH_W-1:0]  divisor;
        logic [CH_W-1:0]  rem;
        logic [CH_W-1:0]  quo;
    } acls_div_t;

endpackage

// ===== design/acls_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acls_div_cell
// One restoring-division step: develops one quotient bit of limit/luminance
// and hands the request on to the next cell.
// ----------------------------------------------------------------------------
module acls_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  acls_pkg::acls_div_t in_item,
    output logic                out_valid,
    output acls_pkg::acls_div_t out_item
);
    import acls_pkg::*;

    logic             valid_reg;
    acls_div_t        item_reg;
    acls_div_t        item_next;
    logic [CH_W:0]    trial;
    logic [CH_W:0]    trial_sub;
    logic             fits;

    // Shift the partial remainder and try the divisor
    always_comb
    begin
        trial     = {in_item.rem, 1'b0};
        trial_sub = trial - {1'b0, in_item.divisor};
        fits      = (trial >= {1'b0, in_item.divisor});
        item_next = in_item;
        item_next.rem = fits ? trial_sub[CH_W-1:0] : trial[CH_W-1:0];
        item_next.quo = {in_item.quo[CH_W-2:0], fits};
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/acls_cell_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acls_cell_mem
// Per-cell colour store: one write and one registered read per cycle,
// with a clearing pass after reset that zeroes every cell.
// ----------------------------------------------------------------------------
module acls_cell_mem #(
    parameter int NUM_CELLS = acls_pkg::GRID_COLUMNS_DEF * acls_pkg::GRID_ROWS_DEF,
    parameter int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [acls_pkg::COLOR_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [acls_pkg::COLOR_W-1:0] wr_data,
    output logic                         busy
);
    import acls_pkg::*;

    logic [COLOR_W-1:0] mem [0:NUM_CELLS-1];
    logic [COLOR_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [ADDR_W-1:0]  clr_cnt_next;
    logic               busy_reg;
    logic               busy_next;

    // Step the clearing pass
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            if (clr_cnt_reg == ADDR_W'(NUM_CELLS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Write: clearing pass first, then updates
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while the pipeline is frozen
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== design/ambient_cell_limit_smooth.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_cell_limit_smooth
// Limits the luminance of each downsampled pixel and blends it into its
// grid cell's stored colour, emitting the cell's updated colour.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                      Contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  cell index, red, green, blue
//  m_axis    out  m_axis_tvalid / m_axis_tready  cell index, smoothed colour
//  cfg       in   cfg_wr_en                      lum_limit, smooth_factor
//
//  One request per cycle while s_axis_tready is high; a result passes through
//  stages 1 and 2, the 16-cell divider chain that forms limit/luminance,
//  stages 3 and 4 and the output register before it is presented on m_axis.
//  After reset a clearing pass zeroes the store's GRID_COLUMNS*GRID_ROWS cells
//  (72 by default) with s_axis_tready low.
//  While m_axis stalls, one result goes to a skid stage; then the whole
//  pipeline and s_axis_tready hold until the skid drains.
// ----------------------------------------------------------------------------
module ambient_cell_limit_smooth #(
    parameter int GRID_COLUMNS = acls_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = acls_pkg::GRID_ROWS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // cell_index[6:0], red_in[14:7], green_in[22:15], blue_in[30:23], zero[31]
    input  logic [31:0]                s_axis_tdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // cell_out[6:0], red_out[22:7], green_out[38:23], blue_out[54:39], zero[55]
    output logic [55:0]                m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [acls_pkg::CFG_W-1:0] cfg_data
);
    import acls_pkg::*;

`include "ambient_cell_limit_smooth_macros.svh"

    localparam int NUM_CELLS = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [31:0]      prod_r;
        logic [31:0]      prod_g;
        logic [31:0]      prod_b;
    } p1_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } color_t;

    // Blend one channel toward its target with floor rounding and saturation
    function automatic logic [CH_W-1:0] blend_ch(
        input logic [CH_W-1:0]  old_v,
        input logic [CH_W-1:0]  tgt_v,
        input logic [CFG_W-1:0] frac
    );
        logic [CH_W:0]      diff;
        logic signed [34:0] prod;
        logic [18:0]        step;
        logic [19:0]        sum;
        logic [CH_W-1:0]    res;
        diff = {1'b0, tgt_v} - {1'b0, old_v};
        prod = $signed(diff) * $signed({1'b0, frac});
        step = prod[34:16];
        sum  = {step[18], step} + {4'b0000, old_v};
        if (sum[19])
        begin
            res = '0;
        end
        else if (sum[18:16] != 3'b000)
        begin
            res = '1;
        end
        else
        begin
            res = sum[CH_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] lum_limit_reg;
    logic [CFG_W-1:0] lum_limit_next;
    logic [CFG_W-1:0] smooth_reg;
    logic [CFG_W-1:0] smooth_next;

    // Pipeline
    logic             adv;
    logic             in_fire;
    logic             mem_busy;
    logic             p1_valid_reg;
    p1_t              p1_reg;
    p1_t              p1_next;
    logic             p2_valid_reg;
    acls_div_t        p2_reg;
    acls_div_t        p2_next;
    logic [31:0]      lum_sum;
    logic             chain_valid [0:DIV_STEPS];
    acls_div_t        chain_item  [0:DIV_STEPS];
    logic             p3_valid_reg;
    color_t           p3_reg;
    color_t           p3_next;
    logic [31:0]      scl_r;
    logic [31:0]      scl_g;
    logic [31:0]      scl_b;
    logic             p4_valid_reg;
    logic             p4_in_range_reg;
    color_t           p4_reg;
    color_t           p4_next;
    logic             p3_in_range;
    logic             fwd;
    color_t           old_color;
    logic [COLOR_W-1:0] rd_data;
    logic [COLOR_W-1:0] wr_data;
    logic             wr_en;

    // Output register and skid
    logic             out_valid_reg;
    logic             out_valid_next;
    color_t           out_reg;
    color_t           out_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    color_t           skid_reg;
    color_t           skid_next;
    logic             out_free;
    logic             push;

    // ------------------------------------------------------------------
    // Configuration writes
    always_comb
    begin
        lum_limit_next = lum_limit_reg;
        smooth_next    = smooth_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LUM_LIMIT: lum_limit_next = cfg_data;
                CFG_SMOOTH:    smooth_next    = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lum_limit_reg <= LUM_LIMIT_RST;
            smooth_reg    <= SMOOTH_RST;
        end
        else
        begin
            lum_limit_reg <= lum_limit_next;
            smooth_reg    <= smooth_next;
        end
    end

    // ------------------------------------------------------------------
    // Hold everything while the skid is occupied
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv && !mem_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Stage 1: widen channels to Q0.16 and weight them
    always_comb
    begin
        p1_next.idx    = s_axis_tdata[6:0];
        p1_next.red    = {s_axis_tdata[14:7],  s_axis_tdata[14:7]};
        p1_next.green  = {s_axis_tdata[22:15], s_axis_tdata[22:15]};
        p1_next.blue   = {s_axis_tdata[30:23], s_axis_tdata[30:23]};
        p1_next.prod_r = {16'd0, p1_next.red}   * {16'd0, WEIGHT_R};
        p1_next.prod_g = {16'd0, p1_next.green} * {16'd0, WEIGHT_G};
        p1_next.prod_b = {16'd0, p1_next.blue}  * {16'd0, WEIGHT_B};
    end

    // Stage 2: sum to luminance, compare against the limit, seed the divider
    always_comb
    begin
        lum_sum         = p1_reg.prod_r + p1_reg.prod_g + p1_reg.prod_b;
        p2_next.idx     = p1_reg.idx;
        p2_next.red     = p1_reg.red;
        p2_next.green   = p1_reg.green;
        p2_next.blue    = p1_reg.blue;
        p2_next.divisor = lum_sum[31:16];
        p2_next.scale   = ({1'b0, lum_sum[31:16]} > lum_limit_reg);
        p2_next.rem     = lum_limit_reg[CH_W-1:0];
        p2_next.quo     = '0;
    end

    // Divider chain, one quotient bit per cell
    assign chain_valid[0] = p2_valid_reg;
    assign chain_item[0]  = p2_reg;

    genvar g;
    for (g = 0; g < DIV_STEPS; g++)
    begin : g_div
        acls_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // Stage 3: scale channels by the quotient when limiting
    always_comb
    begin
        scl_r = {16'd0, chain_item[DIV_STEPS].red}   * {16'd0, chain_item[DIV_STEPS].quo};
        scl_g = {16'd0, chain_item[DIV_STEPS].green} * {16'd0, chain_item[DIV_STEPS].quo};
        scl_b = {16'd0, chain_item[DIV_STEPS].blue}  * {16'd0, chain_item[DIV_STEPS].quo};
        p3_next.idx = chain_item[DIV_STEPS].idx;
        if (chain_item[DIV_STEPS].scale)
        begin
            p3_next.red   = scl_r[31:16];
            p3_next.green = scl_g[31:16];
            p3_next.blue  = scl_b[31:16];
        end
        else
        begin
            p3_next.red   = chain_item[DIV_STEPS].red;
            p3_next.green = chain_item[DIV_STEPS].green;
            p3_next.blue  = chain_item[DIV_STEPS].blue;
        end
    end

    // Cell store, read alongside stage 3
    acls_cell_mem #(
        .NUM_CELLS (NUM_CELLS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (ADDR_W'(chain_item[DIV_STEPS].idx)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(p3_reg.idx)),
        .wr_data (wr_data),
        .busy    (mem_busy)
    );

    // Stage 4: blend into the stored colour; forward the previous update
    // when it hit the same cell, since the store read missed that write
    always_comb
    begin
        p3_in_range = (32'(p3_reg.idx) < 32'(NUM_CELLS));
        fwd         = p4_valid_reg && p4_in_range_reg && (p4_reg.idx == p3_reg.idx);
        old_color.idx = p3_reg.idx;
        if (fwd)
        begin
            old_color.red   = p4_reg.red;
            old_color.green = p4_reg.green;
            old_color.blue  = p4_reg.blue;
        end
        else
        begin
            old_color.red   = rd_data[CH_W-1:0];
            old_color.green = rd_data[2*CH_W-1:CH_W];
            old_color.blue  = rd_data[3*CH_W-1:2*CH_W];
        end
        p4_next.idx   = p3_reg.idx;
        p4_next.red   = '0;
        p4_next.green = '0;
        p4_next.blue  = '0;
        if (p3_in_range)
        begin
            p4_next.red   = blend_ch(old_color.red,   p3_reg.red,   smooth_reg);
            p4_next.green = blend_ch(old_color.green, p3_reg.green, smooth_reg);
            p4_next.blue  = blend_ch(old_color.blue,  p3_reg.blue,  smooth_reg);
        end
        wr_data = {p4_next.blue, p4_next.green, p4_next.red};
        wr_en   = adv && p3_valid_reg && p3_in_range;
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_valid_reg    <= 1'b0;
            p4_valid_reg    <= 1'b0;
            p4_in_range_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg    <= in_fire;
            p2_valid_reg    <= p1_valid_reg;
            p3_valid_reg    <= chain_valid[DIV_STEPS];
            p4_valid_reg    <= p3_valid_reg;
            p4_in_range_reg <= p3_in_range;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry
    assign out_free = !out_valid_reg || m_axis_tready;
    assign push     = adv && p4_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next = 1'b1;
                out_next       = p4_reg;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = p4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.blue, out_reg.green, out_reg.red, out_reg.idx};

    // ------------------------------------------------------------------
    // Checks
    `ACLS_ASSERT_IMP(a_no_accept_while_clearing, clk, rst_n, mem_busy, !s_axis_tready)
    `ACLS_ASSERT_IMP(a_skid_implies_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ACLS_ASSERT_IMP(a_write_only_on_advance, clk, rst_n, wr_en, adv && !mem_busy)
    `ACLS_ASSERT_IMP(a_out_of_grid_zero, clk, rst_n,
        m_axis_tvalid && (32'(m_axis_tdata[6:0]) >= 32'(NUM_CELLS)),
        m_axis_tdata[54:7] == 48'd0)
    `ACLS_ASSERT_NEXT(a_skid_drains, clk, rst_n,
        skid_valid_reg && m_axis_tready, !skid_valid_reg)

endmodule
